// ----- design/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Holds the item structs, the register index codes and the sizing constants.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PAT_LEN = 16;
	localparam int ADDR_W      = 48;

	// fixed by the register layout
	localparam int PAT_BYTES = 16;
	localparam int PIDX_W    = 4;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 48;

	localparam int SEEN_W = $clog2(MAX_PAT_LEN + 1);
	localparam int CMP_W  = ((LEN_W > SEEN_W) ? LEN_W : SEEN_W) + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_WORD0 = 3'd0,
		REG_PAT_WORD1 = 3'd1,
		REG_PAT_WORD2 = 3'd2,
		REG_PAT_WORD3 = 3'd3,
		REG_CMP_MASK  = 3'd4,
		REG_PAT_LEN   = 3'd5,
		REG_BASE_ADDR = 3'd6,
		REG_FIND_ALL  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       range_end;
	} in_item_t;

	typedef struct packed {
		logic              match_found;
		logic [ADDR_W-1:0] match_address;
		logic              scan_done;
	} out_item_t;

endpackage

// ----- design/masked_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte signature match over a stream
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data: data_byte, range_end
//   out       output     out_valid/out_stall out_data: match_found,
//                                            match_address, scan_done
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: a row of window cells compares all
// positions at once and the AND of their results with the address subtract
// fills the result register in the cycle of the transfer.
// Reset clears scan state and registers; find_all resets to one.
// A two-entry result buffer absorbs one stalled result; in_stall rises only
// when both entries are full.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mbps_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mbps_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]      cfg_data
);
	import mbps_pkg::*;

	// configuration
	logic [7:0]        pat_q [PAT_BYTES];
	logic [15:0]       mask_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] base_q;
	logic              find_all_q;

	// scan state
	logic              idle_q;
	logic [SEEN_W-1:0] seen_q;
	logic [ADDR_W-1:0] cur_addr_q;
	logic              first_q;

	logic              accept;
	logic              start;
	logic [7:0]        chain_in [MAX_PAT_LEN];
	logic [7:0]        win_q    [MAX_PAT_LEN];
	logic [MAX_PAT_LEN-1:0] eq;
	logic [CMP_W-1:0]  len_w;
	logic [SEEN_W-1:0] seen_next;
	logic              len_ok;
	logic              hit;
	logic              report;
	logic [ADDR_W-1:0] cur;
	logic              buf_stall;
	out_item_t         res;

	assign accept = in_valid && !buf_stall;
	assign in_stall = buf_stall;
	assign start  = idle_q;
	assign len_w  = CMP_W'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAT_BYTES; i++) begin
				pat_q[i] <= '0;
			end
			mask_q     <= '0;
			len_q      <= '0;
			base_q     <= '0;
			find_all_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_WORD0, REG_PAT_WORD1, REG_PAT_WORD2, REG_PAT_WORD3: begin
					for (int b = 0; b < 4; b++) begin
						pat_q[{cfg_index[1:0], 2'(b)}] <= cfg_data[8*b +: 8];
					end
				end
				REG_CMP_MASK:  mask_q     <= cfg_data[15:0];
				REG_PAT_LEN:   len_q      <= cfg_data[LEN_W-1:0];
				REG_BASE_ADDR: base_q     <= ADDR_W'(cfg_data);
				REG_FIND_ALL:  find_all_q <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// window cells; a scan start clears the older positions as the byte enters
	genvar j;
	generate
		for (j = 0; j < MAX_PAT_LEN; j++) begin : g_cell
			logic [CMP_W-1:0] k_j;
			logic             use_j;
			logic             care_j;

			if (j == 0) begin : g_head
				assign chain_in[j] = in_data.data_byte;
			end else begin : g_body
				assign chain_in[j] = start ? 8'd0 : win_q[j-1];
			end

			// window position j lines up with pattern byte len - 1 - j
			assign use_j  = len_w > CMP_W'(j);
			assign k_j    = len_w - CMP_W'(j + 1);
			assign care_j = use_j && (k_j < CMP_W'(PAT_BYTES)) && mask_q[k_j[PIDX_W-1:0]];

			mbps_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (accept),
				.d_in  (chain_in[j]),
				.pat   (pat_q[k_j[PIDX_W-1:0]]),
				.care  (care_j),
				.q     (win_q[j]),
				.eq    (eq[j])
			);
		end
	endgenerate

	always_comb begin
		if (start) begin
			seen_next = SEEN_W'(1);
		end else if (seen_q == SEEN_W'(MAX_PAT_LEN)) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + SEEN_W'(1);
		end
	end

	assign len_ok = (len_q != '0) && (len_w <= CMP_W'(MAX_PAT_LEN))
		&& (CMP_W'(seen_next) >= len_w);
	assign hit    = len_ok && (&eq);
	assign report = hit && (find_all_q || start || !first_q);
	assign cur    = start ? base_q : cur_addr_q;

	always_comb begin
		res.match_found   = report;
		res.match_address = report ? (cur - ADDR_W'(len_q) + ADDR_W'(1)) : '0;
		res.scan_done     = in_data.range_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q     <= 1'b1;
			seen_q     <= '0;
			cur_addr_q <= '0;
			first_q    <= 1'b0;
		end else if (accept) begin
			idle_q     <= in_data.range_end;
			seen_q     <= seen_next;
			cur_addr_q <= cur + ADDR_W'(1);
			first_q    <= report || (!start && first_q);
		end
	end

	mbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(in_valid),
		.push_stall(buf_stall),
		.push_data (res),
		.pop_valid (out_valid),
		.pop_stall (out_stall),
		.pop_data  (out_data)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output register empty");

	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("transfer in gave no result");

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(MAX_PAT_LEN))
		else $error("byte count above window depth");

	a_first_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !find_all_q && !start && first_q) |-> !report)
		else $error("second match reported in find-first mode");

endmodule

// ----- design/mbps_cell.sv -----
// ----------------------------------------------------------------------------
// mbps_cell: one window position of the scanner
// Holds one byte of the sliding window, hands it to the next cell on each
// transfer and compares the byte it is about to take against its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] d_in,
	input  logic [7:0] pat,
	input  logic       care,
	output logic [7:0] q,
	output logic       eq
);

	logic [7:0] byte_q;

	// compare the incoming byte, so the match reflects the window after shifting
	assign eq = !care || (d_in == pat);
	assign q  = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d_in;
		end
	end

endmodule

// ----- design/mbps_out_buf.sv -----
// ----------------------------------------------------------------------------
// mbps_out_buf: two-entry result buffer
// Output register plus a skid entry, so the input side stalls only from a
// registered full flag.
// ----------------------------------------------------------------------------
module mbps_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_stall,
	input  mbps_pkg::out_item_t push_data,
	output logic                pop_valid,
	input  logic                pop_stall,
	output mbps_pkg::out_item_t pop_data
);
	import mbps_pkg::*;

	out_item_t main_q;
	out_item_t skid_q;
	logic      main_v_q;
	logic      skid_v_q;
	logic      pop;
	logic      push;

	assign pop        = main_v_q && !pop_stall;
	assign push       = push_valid && !skid_v_q;
	assign push_stall = skid_v_q;
	assign pop_valid  = main_v_q;
	assign pop_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// drain the skid entry into the output register
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule
